### rtl/cec_pkg.sv
// Package for the two-circle elastic collision pipeline.
// Holds the request and response types, datapath widths and small helper functions.
// Used by cec_corr and circle_elastic_collision; depends on nothing else.
package cec_pkg;

   localparam int DIFF_W    = 17;  // centre and velocity differences
   localparam int SQ_W      = 34;  // squares and dot-product terms
   localparam int DOT_W     = 35;  // projection s = dv.d
   localparam int MASS2_W   = 17;  // twice a mass, or the mass sum
   localparam int SMAG_W    = 34;  // |s|
   localparam int DMAG_W    = 16;  // |dx|, |dy|
   localparam int PROD_W    = SMAG_W + DMAG_W;
   localparam int PROD_HALF = PROD_W / 2;
   localparam int PART_W    = MASS2_W + PROD_HALF;
   localparam int NUM_W     = MASS2_W + PROD_W;
   localparam int DEN_W     = 49;  // mass sum times squared distance
   localparam int QUO_BITS  = 20;  // corrections are capped at 2^QUO_BITS
   localparam int REM_W     = DEN_W + QUO_BITS;
   localparam int MAG_W     = QUO_BITS + 1;
   localparam int CORR_W    = MAG_W + 1;
   localparam int SUM_W     = 23;
   localparam int CORR_LAT  = QUO_BITS + 4;
   localparam int FRONT_LAT = 4;
   localparam int TOTAL_LAT = FRONT_LAT + CORR_LAT + 1;

   typedef struct packed {
      logic signed [15:0] a_pos_x;
      logic signed [15:0] a_pos_y;
      logic signed [15:0] b_pos_x;
      logic signed [15:0] b_pos_y;
      logic signed [15:0] a_vel_x;
      logic signed [15:0] a_vel_y;
      logic signed [15:0] b_vel_x;
      logic signed [15:0] b_vel_y;
      logic [14:0]        a_radius;
      logic [14:0]        b_radius;
      logic [15:0]        a_mass;
      logic [15:0]        b_mass;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] a_new_vel_x;
      logic signed [15:0] a_new_vel_y;
      logic signed [15:0] b_new_vel_x;
      logic signed [15:0] b_new_vel_y;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] bx;
      logic [15:0] by;
   } vel_type;

   function automatic logic signed [DIFF_W-1:0] sx17(input logic [15:0] v);
      return {v[15], v};
   endfunction

   function automatic logic signed [SUM_W-1:0] ext23(input logic [15:0] v);
      return {{(SUM_W-16){v[15]}}, v};
   endfunction

   function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] v);
      logic [15:0] r;
      if (v > 23'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -23'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### rtl/cec_corr.sv
// One velocity correction: round(mass2 * p / den), ties away from zero, capped.
// Pipelined restoring division, one quotient bit per stage.
// Depends on cec_pkg.
module cec_corr (
   input  logic                                  clock,
   input  logic [cec_pkg::MASS2_W-1:0]           mass2,
   input  logic [cec_pkg::PROD_W-1:0]            prod,
   input  logic                                  neg,
   input  logic [cec_pkg::DEN_W-1:0]             den,
   output logic signed [cec_pkg::CORR_W-1:0]     corr
);
   import cec_pkg::*;

   logic [PART_W-1:0] lo_ff, hi_ff;
   logic [DEN_W-1:0]  den0_ff, den1_ff;
   logic              neg0_ff, neg1_ff;
   logic [NUM_W-1:0]  num_ff;

   logic [REM_W-1:0]    rem_ff  [0:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff  [0:QUO_BITS];
   logic [DEN_W-1:0]    dens_ff [0:QUO_BITS];
   logic                negs_ff [0:QUO_BITS];
   logic                ovf_ff  [0:QUO_BITS];

   logic                      up_in;
   logic [MAG_W-1:0]          mag_in;
   logic signed [CORR_W-1:0]  corr_in, corr_ff;

   // Split the wide product into two narrow partial products, add them back up and load the first division stage.
   always_ff @(posedge clock) begin
      lo_ff   <= mass2 * prod[PROD_HALF-1:0];
      hi_ff   <= mass2 * prod[PROD_W-1:PROD_HALF];
      den0_ff <= den;
      neg0_ff <= neg;
      num_ff  <= (NUM_W'(hi_ff) << PROD_HALF) + NUM_W'(lo_ff);
      den1_ff <= den0_ff;
      neg1_ff <= neg0_ff;
      // A quotient of 2^QUO_BITS or more is capped, so only the low bits are worked out.
      ovf_ff[0]  <= REM_W'(num_ff) >= (REM_W'(den1_ff) << QUO_BITS);
      rem_ff[0]  <= REM_W'(num_ff);
      quo_ff[0]  <= '0;
      dens_ff[0] <= den1_ff;
      negs_ff[0] <= neg1_ff;
   end

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_bit
      localparam int Bit = QUO_BITS - 1 - k;
      logic [REM_W-1:0] shifted;
      logic             take;
      always_comb begin
         shifted = REM_W'(dens_ff[k]) << Bit;
         take    = rem_ff[k] >= shifted;
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take ? rem_ff[k] - shifted : rem_ff[k];
         quo_ff[k+1]  <= quo_ff[k] | (QUO_BITS'(take) << Bit);
         dens_ff[k+1] <= dens_ff[k];
         negs_ff[k+1] <= negs_ff[k];
         ovf_ff[k+1]  <= ovf_ff[k];
      end
   end

   always_comb begin
      up_in  = {rem_ff[QUO_BITS][DEN_W-1:0], 1'b0} >= {1'b0, dens_ff[QUO_BITS]};
      mag_in = ovf_ff[QUO_BITS] ? (MAG_W'(1) << QUO_BITS)
                                : {1'b0, quo_ff[QUO_BITS]} + MAG_W'(up_in);
      corr_in = negs_ff[QUO_BITS] ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
   end

   always_ff @(posedge clock) begin
      corr_ff <= corr_in;
   end

   assign corr = corr_ff;

endmodule

### rtl/circle_elastic_collision.sv
// Top level of the two-circle elastic collision pipeline.
// Front stages form differences, squares and the projection; four cec_corr units divide.
// Depends on cec_pkg and cec_corr.
//
//   channel    ports                 direction   handshake
//   request    start, busy, req_data in          taken when start is high and busy low
//   response   rsp_valid, rsp_data   out         strobe for one cycle, cannot be held off
//
// A request can be taken in every cycle; its response passes the front stages, the dividers and the response register.
// The latency is set by the quotient pipeline of the dividers, one bit per stage.
// Reset clears only the valid bits of the pipeline; busy never rises.
// Nothing stalls, so the pipeline advances in every cycle.
module circle_elastic_collision (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cec_pkg::req_type  req_data,
   output logic              rsp_valid,
   output cec_pkg::rsp_type  rsp_data
);
   import cec_pkg::*;

   // Stage 1: differences.
   logic                       v1_ff;
   logic signed [DIFF_W-1:0]   dx1_ff, dy1_ff, dvx1_ff, dvy1_ff;
   logic [15:0]                rs1_ff;
   logic [MASS2_W-1:0]         msum1_ff, ma2_1_ff, mb2_1_ff;
   vel_type                    vel1_ff;

   // Stage 2: squares and projection terms.
   logic                       v2_ff;
   logic [SQ_W-1:0]            dd2_ff;
   logic [31:0]                rr2_ff;
   logic signed [SQ_W-1:0]     sx2_ff, sy2_ff;
   logic signed [DIFF_W-1:0]   dx2_ff, dy2_ff;
   logic [MASS2_W-1:0]         msum2_ff, ma2_2_ff, mb2_2_ff;
   vel_type                    vel2_ff;
   logic signed [SQ_W-1:0]     sqx_in, sqy_in;

   // Stage 3: overlap test, projection and divisor.
   logic                       v3_ff, hit3_ff;
   logic signed [DOT_W-1:0]    s3_ff;
   logic [DEN_W-1:0]           den3_ff;
   logic signed [DIFF_W-1:0]   dx3_ff, dy3_ff;
   logic [MASS2_W-1:0]         ma2_3_ff, mb2_3_ff;
   vel_type                    vel3_ff;

   // Stage 4: magnitudes and the shared products |s|*|d|.
   logic                       v4_ff, hit4_ff, negx4_ff, negy4_ff;
   logic [PROD_W-1:0]          px4_ff, py4_ff;
   logic [DEN_W-1:0]           den4_ff;
   logic [MASS2_W-1:0]         ma2_4_ff, mb2_4_ff;
   vel_type                    vel4_ff;
   logic [SMAG_W-1:0]          smag_in;
   logic [DMAG_W-1:0]          dxmag_in, dymag_in;

   // Side line that runs beside the dividers.
   logic                       vd_ff   [0:CORR_LAT-1];
   logic                       hitd_ff [0:CORR_LAT-1];
   vel_type                    veld_ff [0:CORR_LAT-1];

   logic signed [CORR_W-1:0]   corr_ax, corr_ay, corr_bx, corr_by;
   rsp_type                    rsp_in, rsp_ff;
   logic                       rsp_valid_ff;
   vel_type                    vel_last;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      dx1_ff   <= sx17(req_data.a_pos_x) - sx17(req_data.b_pos_x);
      dy1_ff   <= sx17(req_data.a_pos_y) - sx17(req_data.b_pos_y);
      dvx1_ff  <= sx17(req_data.a_vel_x) - sx17(req_data.b_vel_x);
      dvy1_ff  <= sx17(req_data.a_vel_y) - sx17(req_data.b_vel_y);
      rs1_ff   <= 16'(req_data.a_radius) + 16'(req_data.b_radius);
      msum1_ff <= MASS2_W'(req_data.a_mass) + MASS2_W'(req_data.b_mass);
      ma2_1_ff <= {req_data.a_mass, 1'b0};
      mb2_1_ff <= {req_data.b_mass, 1'b0};
      vel1_ff  <= '{ax: req_data.a_vel_x, ay: req_data.a_vel_y,
                    bx: req_data.b_vel_x, by: req_data.b_vel_y};
   end

   always_comb begin
      sqx_in = dx1_ff * dx1_ff;
      sqy_in = dy1_ff * dy1_ff;
   end

   always_ff @(posedge clock) begin
      dd2_ff   <= SQ_W'(sqx_in) + SQ_W'(sqy_in);
      rr2_ff   <= rs1_ff * rs1_ff;
      sx2_ff   <= dvx1_ff * dx1_ff;
      sy2_ff   <= dvy1_ff * dy1_ff;
      dx2_ff   <= dx1_ff;
      dy2_ff   <= dy1_ff;
      msum2_ff <= msum1_ff;
      ma2_2_ff <= ma2_1_ff;
      mb2_2_ff <= mb2_1_ff;
      vel2_ff  <= vel1_ff;
   end

   always_ff @(posedge clock) begin
      hit3_ff  <= dd2_ff < {2'b00, rr2_ff} && dd2_ff != '0 && msum2_ff != '0;
      s3_ff    <= $signed({sx2_ff[SQ_W-1], sx2_ff}) + $signed({sy2_ff[SQ_W-1], sy2_ff});
      den3_ff  <= msum2_ff * dd2_ff[31:0];
      dx3_ff   <= dx2_ff;
      dy3_ff   <= dy2_ff;
      ma2_3_ff <= ma2_2_ff;
      mb2_3_ff <= mb2_2_ff;
      vel3_ff  <= vel2_ff;
   end

   always_comb begin
      smag_in  = s3_ff[DOT_W-1] ? SMAG_W'(-s3_ff) : SMAG_W'(s3_ff);
      dxmag_in = dx3_ff[DIFF_W-1] ? DMAG_W'(-dx3_ff) : DMAG_W'(dx3_ff);
      dymag_in = dy3_ff[DIFF_W-1] ? DMAG_W'(-dy3_ff) : DMAG_W'(dy3_ff);
   end

   always_ff @(posedge clock) begin
      px4_ff   <= smag_in * dxmag_in;
      py4_ff   <= smag_in * dymag_in;
      negx4_ff <= s3_ff[DOT_W-1] ^ dx3_ff[DIFF_W-1];
      negy4_ff <= s3_ff[DOT_W-1] ^ dy3_ff[DIFF_W-1];
      hit4_ff  <= hit3_ff;
      den4_ff  <= den3_ff;
      ma2_4_ff <= ma2_3_ff;
      mb2_4_ff <= mb2_3_ff;
      vel4_ff  <= vel3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int i = 0; i < CORR_LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff[0] <= v4_ff;
         for (int i = 1; i < CORR_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         rsp_valid_ff <= vd_ff[CORR_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      hitd_ff[0] <= hit4_ff;
      veld_ff[0] <= vel4_ff;
      for (int i = 1; i < CORR_LAT; i++) begin
         hitd_ff[i] <= hitd_ff[i-1];
         veld_ff[i] <= veld_ff[i-1];
      end
   end

   // Circle A loses its share along the centre line, circle B gains it.
   cec_corr u_corr_ax (.clock, .mass2(mb2_4_ff), .prod(px4_ff), .neg(negx4_ff),
                       .den(den4_ff), .corr(corr_ax));
   cec_corr u_corr_ay (.clock, .mass2(mb2_4_ff), .prod(py4_ff), .neg(negy4_ff),
                       .den(den4_ff), .corr(corr_ay));
   cec_corr u_corr_bx (.clock, .mass2(ma2_4_ff), .prod(px4_ff), .neg(negx4_ff),
                       .den(den4_ff), .corr(corr_bx));
   cec_corr u_corr_by (.clock, .mass2(ma2_4_ff), .prod(py4_ff), .neg(negy4_ff),
                       .den(den4_ff), .corr(corr_by));

   always_comb begin
      vel_last = veld_ff[CORR_LAT-1];
      rsp_in.hit = hitd_ff[CORR_LAT-1];
      if (hitd_ff[CORR_LAT-1]) begin
         rsp_in.a_new_vel_x = sat16(ext23(vel_last.ax) - SUM_W'(corr_ax));
         rsp_in.a_new_vel_y = sat16(ext23(vel_last.ay) - SUM_W'(corr_ay));
         rsp_in.b_new_vel_x = sat16(ext23(vel_last.bx) + SUM_W'(corr_bx));
         rsp_in.b_new_vel_y = sat16(ext23(vel_last.by) + SUM_W'(corr_by));
      end else begin
         rsp_in.a_new_vel_x = vel_last.ax;
         rsp_in.a_new_vel_y = vel_last.ay;
         rsp_in.b_new_vel_x = vel_last.bx;
         rsp_in.b_new_vel_y = vel_last.by;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every response stems from a request that was taken earlier.
   a_resp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, TOTAL_LAT))
      else $error("response without a matching request");

   // Without an exchange the velocities come back untouched; the checks here cover a_vel_x and b_vel_y.
   a_pass_ax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.a_new_vel_x == $past(req_data.a_vel_x, TOTAL_LAT))
      else $error("velocity changed without a hit");

   a_pass_by: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.b_new_vel_y == $past(req_data.b_vel_y, TOTAL_LAT))
      else $error("velocity changed without a hit");

   // A hit needs separate centres.
   a_hit_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         ($past(req_data.a_pos_x, TOTAL_LAT) != $past(req_data.b_pos_x, TOTAL_LAT)) ||
         ($past(req_data.a_pos_y, TOTAL_LAT) != $past(req_data.b_pos_y, TOTAL_LAT)))
      else $error("hit reported for coincident centres");

endmodule

### tb/cec_checker.sv
// Checker for the circle elastic collision block: watches request and response ports.
// Predicts each response from the accepted request and compares it field by field.
// Depends on cec_pkg.
`timescale 1ns / 100ps

module cec_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  cec_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  cec_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import cec_pkg::*;

   rsp_type collision_queue[$];

   // Rounded quotient num/den, ties away from zero, capped at 2^20.
   function automatic longint quot_round(input logic [127:0] num, input logic [63:0] den);
      logic [127:0] q;
      logic [127:0] r;
      q = num / den;
      r = num % den;
      if (q >= (128'd1 << 20)) return longint'(1 << 20);
      if (2 * r >= den) q = q + 1;
      return longint'(q[63:0]);
   endfunction

   function automatic longint axis_corr(input longint mass2, input longint s,
                                        input longint dc, input logic [63:0] den);
      logic [127:0] num;
      longint q;
      num = 128'(mass2) * 128'(s < 0 ? -s : s) * 128'(dc < 0 ? -dc : dc);
      q = quot_round(num, den);
      return ((s < 0) != (dc < 0)) ? -q : q;
   endfunction

   function automatic logic [15:0] clamp16(input longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic rsp_type predict_collision(input req_type r);
      rsp_type o;
      longint dx, dy, dd, rs, msum, s, nax, nay, nbx, nby;
      logic [63:0] den;
      dx = longint'(r.a_pos_x) - longint'(r.b_pos_x);
      dy = longint'(r.a_pos_y) - longint'(r.b_pos_y);
      dd = dx * dx + dy * dy;
      rs = longint'(r.a_radius) + longint'(r.b_radius);
      msum = longint'(r.a_mass) + longint'(r.b_mass);
      nax = r.a_vel_x;
      nay = r.a_vel_y;
      nbx = r.b_vel_x;
      nby = r.b_vel_y;
      o.hit = (dd < rs * rs) && dd != 0 && msum != 0;
      if (o.hit) begin
         s = (nax - nbx) * dx + (nay - nby) * dy;
         den = 64'(msum * dd);
         nax = nax - axis_corr(2 * longint'(r.b_mass), s, dx, den);
         nay = nay - axis_corr(2 * longint'(r.b_mass), s, dy, den);
         nbx = nbx + axis_corr(2 * longint'(r.a_mass), s, dx, den);
         nby = nby + axis_corr(2 * longint'(r.a_mass), s, dy, den);
      end
      o.a_new_vel_x = clamp16(nax);
      o.a_new_vel_y = clamp16(nay);
      o.b_new_vel_x = clamp16(nbx);
      o.b_new_vel_y = clamp16(nby);
      return o;
   endfunction

   assign pending = collision_queue.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (collision_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = collision_queue.pop_front();
               if (e !== rsp_data) begin
                  if (e.hit !== rsp_data.hit)
                     $error("hit expected %0d actual %0d", e.hit, rsp_data.hit);
                  if (e.a_new_vel_x !== rsp_data.a_new_vel_x)
                     $error("a_new_vel_x expected %0d actual %0d",
                            e.a_new_vel_x, rsp_data.a_new_vel_x);
                  if (e.a_new_vel_y !== rsp_data.a_new_vel_y)
                     $error("a_new_vel_y expected %0d actual %0d",
                            e.a_new_vel_y, rsp_data.a_new_vel_y);
                  if (e.b_new_vel_x !== rsp_data.b_new_vel_x)
                     $error("b_new_vel_x expected %0d actual %0d",
                            e.b_new_vel_x, rsp_data.b_new_vel_x);
                  if (e.b_new_vel_y !== rsp_data.b_new_vel_y)
                     $error("b_new_vel_y expected %0d actual %0d",
                            e.b_new_vel_y, rsp_data.b_new_vel_y);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) collision_queue.push_back(predict_collision(req_data));
      end
   end
endmodule

### tb/tb.sv
// Testbench top for circle_elastic_collision: drives requests and gives the verdict.
// Depends on cec_pkg, the block and cec_checker.
`timescale 1ns / 100ps

module tb;
   import cec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;
   bit      stimulus_done = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   circle_elastic_collision dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   cec_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset || stimulus_done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL circle_elastic_collision");
         $finish;
      end
   end

   function automatic logic [15:0] rand_mass();
      logic [15:0] m;
      m = 16'($urandom);
      if (m == 0) m = 1;
      return m;
   endfunction

   // Mostly overlapping pairs near each other so that the exchange path is exercised.
   function automatic req_type rand_request();
      req_type r;
      int k;
      k = $urandom_range(0, 9);
      r.a_vel_x = 16'($urandom);
      r.a_vel_y = 16'($urandom);
      r.b_vel_x = 16'($urandom);
      r.b_vel_y = 16'($urandom);
      r.a_pos_x = 16'($urandom);
      r.a_pos_y = 16'($urandom);
      r.a_radius = 15'($urandom);
      r.b_radius = 15'($urandom);
      r.a_mass = rand_mass();
      r.b_mass = rand_mass();
      if (k < 7) begin
         r.b_pos_x = r.a_pos_x + 16'($urandom_range(0, 8000)) - 16'd4000;
         r.b_pos_y = r.a_pos_y + 16'($urandom_range(0, 8000)) - 16'd4000;
         if (k < 2) begin
            r.a_vel_x = 16'($urandom_range(0, 1024)) - 16'd512;
            r.b_vel_y = 16'($urandom_range(0, 1024)) - 16'd512;
            r.a_mass = 16'($urandom_range(1, 1024));
         end
      end else if (k == 7) begin
         r.b_pos_x = r.a_pos_x;
         r.b_pos_y = r.a_pos_y;
      end else begin
         r.b_pos_x = 16'($urandom);
         r.b_pos_y = 16'($urandom);
      end
      return r;
   endfunction

   function automatic req_type directed_request(input int n);
      req_type r;
      r = '0;
      r.a_mass = 16'h0100;
      r.b_mass = 16'h0100;
      r.a_radius = 15'h0100;
      r.b_radius = 15'h0100;
      r.b_pos_x = 16'h0100;
      r.a_vel_x = 16'h0100;
      case (n)
         0: ;                                                   // head-on, equal masses
         1: r.b_pos_x = 16'h0000;                               // coincident centres
         2: r.b_pos_x = 16'h0200;                               // touching only
         3: begin r.b_pos_x = 16'h7FFF; r.a_pos_x = 16'h8000; end  // far apart
         4: begin r.a_radius = 15'h7FFF; r.b_radius = 15'h7FFF;
                  r.a_pos_x = 16'h8000; r.b_pos_x = 16'h7FFF;
                  r.a_pos_y = 16'h8000; r.b_pos_y = 16'h7FFF; end
         5: begin r.a_vel_x = 16'h7FFF; r.b_vel_x = 16'h8000; end
         6: begin r.a_vel_x = 16'h8000; r.b_vel_x = 16'h7FFF;
                  r.a_vel_y = 16'h8000; r.b_vel_y = 16'h7FFF; end
         7: begin r.a_mass = 16'h0001; r.b_mass = 16'hFFFF; end
         8: begin r.a_mass = 16'hFFFF; r.b_mass = 16'h0001; end
         9: begin r.a_mass = 16'hFFFF; r.b_mass = 16'hFFFF; r.b_pos_y = 16'h0080; end
         10: begin r.b_pos_x = 16'h0001; r.a_vel_x = 16'h7FFF; r.a_mass = 16'h0001;
                   r.b_mass = 16'hFFFF; end                       // large correction on circle A
         11: begin r.b_pos_x = 16'hFFFF; r.b_pos_y = 16'h0001; r.a_vel_y = 16'h8000; end
         12: begin r.b_pos_x = 16'h00B5; r.b_pos_y = 16'h00B5; r.b_vel_y = 16'hFF00; end
         13: begin r.a_vel_x = 16'hFF00; end                       // separating pair
         default: r = rand_request();
      endcase
      return r;
   endfunction

   task automatic send_request(input req_type r, input bit allow_gaps);
      int gap;
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      int wait_count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 20; n++) send_request(directed_request(n), 1'b1);
      for (int n = 0; n < 550; n++) send_request(rand_request(), n < 450);
      start <= 1'b0;
      stimulus_done = 1;
      wait_count = 0;
      while (pending != 0 && wait_count < 200) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (TOTAL_LAT + 5) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS circle_elastic_collision");
      end else begin
         $display("FAIL circle_elastic_collision");
      end
      $finish;
   end
endmodule
